### src/can_node_command_decoder_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the can node command decoder
// concurrent checks sampled on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef CAN_NODE_COMMAND_DECODER_ASSERT_SVH
`define CAN_NODE_COMMAND_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define CND_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("can node decoder check failed");

// consequent must hold in the cycle after the antecedent
`define CND_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("can node decoder check failed");

`else

`define CND_ASSERT_SAME(label, ante, cons)
`define CND_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/cnd_pkg.sv
// ---------------------------------------------------------------------------
// cnd_pkg
// types, codes and constants shared by the can node command decoder
// ---------------------------------------------------------------------------
package cnd_pkg;

	// node numbering
	localparam logic [5:0] NODE_UNASSIGNED = 6'd63;
	localparam logic [7:0] NODE_MIN        = 8'd1;
	localparam logic [7:0] NODE_MAX        = 8'd60;

	// command codes in byte 0
	localparam logic [7:0] CMD_TIME_SET   = 8'h01;
	localparam logic [7:0] CMD_HB_OFF     = 8'h02;
	localparam logic [7:0] CMD_HB_ON      = 8'h03;
	localparam logic [7:0] CMD_FLASH_CLR  = 8'h04;
	localparam logic [7:0] CMD_HISTORY    = 8'h05;
	localparam logic [7:0] CMD_CHIP_ID    = 8'h06;
	localparam logic [7:0] CMD_ID_ASSIGN  = 8'h2a;
	localparam logic [7:0] CMD_CHARGE     = 8'h2b;
	localparam logic [7:0] CMD_VOLUME     = 8'h2c;

	// byte 1 mark and the power-off byte pattern
	localparam logic [7:0] CMD_MARK       = 8'hff;
	localparam logic [7:0] PWR_OFF_BYTE0  = 8'h55;
	localparam logic [7:0] PWR_OFF_BYTE1  = 8'haa;

	// action mask bits
	localparam logic [6:0] ACT_POWER_OFF = 7'h01;
	localparam logic [6:0] ACT_RELAY     = 7'h02;
	localparam logic [6:0] ACT_BATTERY   = 7'h04;
	localparam logic [6:0] ACT_CHARGE    = 7'h08;
	localparam logic [6:0] ACT_VOLUME    = 7'h10;
	localparam logic [6:0] ACT_TIME      = 7'h20;
	localparam logic [6:0] ACT_SOUND     = 7'h40;

	// configuration register indexes
	localparam logic [1:0] CFG_CHIP_ID     = 2'd0;
	localparam logic [1:0] CFG_ORDER_CLASS = 2'd1;
	localparam logic [1:0] CFG_SOUND_CLASS = 2'd2;

	localparam logic [1:0] SOUND_CLASS_RST = 2'd3;

	typedef enum logic [2:0] {
		REPLY_NONE    = 3'd0,
		REPLY_ACK_ID  = 3'd1,
		REPLY_CHIP_ID = 3'd2,
		REPLY_FLASH   = 3'd3,
		REPLY_HISTORY = 3'd4
	} reply_t;

	typedef struct packed {
		logic        is_standard;
		logic [10:0] frame_id;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b4;
		logic [7:0]  b5;
		logic [7:0]  b6;
		logic [7:0]  b7;
		logic        relay_hold;
	} frame_t;

	typedef struct packed {
		logic        assigned;
		logic [5:0]  node;
		logic        heartbeat;
		logic [47:0] clock;
		logic [63:0] sound;
	} node_state_t;

	typedef struct packed {
		reply_t      reply;
		logic [6:0]  mask;
		logic [7:0]  value;
	} result_t;

	typedef struct packed {
		logic [31:0] chip_id;
		logic [1:0]  order_class;
		logic [1:0]  sound_class;
	} cfg_t;

endpackage

### src/cnd_decode.sv
// ---------------------------------------------------------------------------
// cnd_decode
// combinational decode of one frame against the node state
// ---------------------------------------------------------------------------
module cnd_decode
	import cnd_pkg::*;
(
	input  frame_t      frame,
	input  node_state_t cur,
	input  cfg_t        cfg,
	output node_state_t nxt,
	output result_t     res
);

	logic        done;
	logic [31:0] frame_chip;
	logic        newid_ok;
	logic        addr_hit;
	logic        unassigned;

	function automatic logic cmd_is(input frame_t f, input logic [7:0] code);
		cmd_is = (f.b0 == code) && (f.b1 == CMD_MARK);
	endfunction

	assign frame_chip = {frame.b5, frame.b4, frame.b3, frame.b2};
	assign newid_ok   = (frame.b6 >= NODE_MIN) && (frame.b6 <= NODE_MAX);
	// all seven address bits take part, so bit 6 set never matches
	assign addr_hit   = (frame.frame_id[6:0] == {1'b0, cur.node});
	assign unassigned = !cur.assigned || (cur.node == NODE_UNASSIGNED);

	always_comb begin
		nxt       = cur;
		res.reply = REPLY_NONE;
		res.mask  = '0;
		res.value = '0;
		done      = 1'b0;

		if (frame.is_standard) begin
			if (frame.frame_id[10:9] == cfg.order_class) begin
				done = 1'b1;
				if (frame.b0 == PWR_OFF_BYTE0 && frame.b1 == PWR_OFF_BYTE1) begin
					res.mask = res.mask | ACT_POWER_OFF;
				end
				if (unassigned && !frame.relay_hold) begin
					if (cmd_is(frame, CMD_ID_ASSIGN) && frame_chip == '0 && newid_ok) begin
						nxt.assigned = 1'b1;
						nxt.node     = frame.b6[5:0];
						res.reply    = REPLY_ACK_ID;
						res.mask     = res.mask | ACT_RELAY | ACT_BATTERY;
					end
				end else if (cur.assigned && !frame.relay_hold
						&& cmd_is(frame, CMD_TIME_SET)) begin
					nxt.clock = {frame.b2, frame.b3, frame.b4, frame.b5, frame.b6, frame.b7};
					res.mask  = res.mask | ACT_TIME;
				end else if (cur.assigned && !frame.relay_hold
						&& cmd_is(frame, CMD_ID_ASSIGN) && frame_chip == cfg.chip_id) begin
					if (newid_ok) begin
						nxt.node  = frame.b6[5:0];
						res.mask  = res.mask | ACT_RELAY;
						res.reply = REPLY_ACK_ID;
					end
				end else if (cmd_is(frame, CMD_HB_OFF)) begin
					nxt.heartbeat = 1'b0;
				end else if (cmd_is(frame, CMD_HB_ON)) begin
					nxt.heartbeat = 1'b1;
				end else if (cmd_is(frame, CMD_FLASH_CLR)) begin
					res.reply = REPLY_FLASH;
				end else if (addr_hit && cmd_is(frame, CMD_CHARGE)) begin
					res.mask  = res.mask | ACT_CHARGE;
					res.value = frame.b2;
					res.reply = REPLY_ACK_ID;
				end else if (addr_hit && cmd_is(frame, CMD_HISTORY)) begin
					res.reply = REPLY_HISTORY;
				end else if (addr_hit && cmd_is(frame, CMD_CHIP_ID)) begin
					res.reply = REPLY_CHIP_ID;
				end else if (addr_hit && cmd_is(frame, CMD_VOLUME)) begin
					res.mask  = res.mask | ACT_VOLUME;
					res.value = frame.b2;
					res.reply = REPLY_ACK_ID;
				end else begin
					done = 1'b0;
				end
			end
			// falls through to the sound class test
			if (!done && frame.frame_id[8:7] == cfg.sound_class) begin
				nxt.sound = {frame.b7, frame.b6, frame.b5, frame.b4,
					frame.b3, frame.b2, frame.b1, frame.b0};
				res.mask  = res.mask | ACT_SOUND;
			end
		end
	end

endmodule

### src/can_node_command_decoder.sv
// ---------------------------------------------------------------------------
// can_node_command_decoder
// decodes one received can frame per word for a daisy-chained node
// ---------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  in        in_valid / in_ready     is_standard, frame_id, data_byte0..7,
//                                    relay_hold
//  out       out_valid / out_ready   reply_code, action_mask, action_value,
//                                    node_id, assigned, heartbeat_on,
//                                    clock_value, sound_payload
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
//  one word per cycle sustained while out_ready holds; an accepted word goes
//  into the input register, then is decoded into the result register
//  node state updates at the same edge that loads the result register
//  reset gives node 63 unassigned, heartbeat on, clock and sound cleared
//  a stalled output holds the input stage, which still takes a word if empty
//
module can_node_command_decoder
	import cnd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        is_standard,
	input  logic [10:0] frame_id,
	input  logic [7:0]  data_byte0,
	input  logic [7:0]  data_byte1,
	input  logic [7:0]  data_byte2,
	input  logic [7:0]  data_byte3,
	input  logic [7:0]  data_byte4,
	input  logic [7:0]  data_byte5,
	input  logic [7:0]  data_byte6,
	input  logic [7:0]  data_byte7,
	input  logic        relay_hold,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  reply_code,
	output logic [6:0]  action_mask,
	output logic [7:0]  action_value,
	output logic [5:0]  node_id,
	output logic        assigned,
	output logic        heartbeat_on,
	output logic [47:0] clock_value,
	output logic [63:0] sound_payload,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "can_node_command_decoder_assert.svh"

	// configuration registers
	cfg_t        cfg_q;

	// input stage
	logic        valid_s1;
	frame_t      frame_s1;

	// node state
	node_state_t state_q;
	node_state_t state_nxt;

	// result register
	logic        out_valid_q;
	result_t     result_q;
	node_state_t out_state_q;
	result_t     result_nxt;

	logic        advance;

	// the decode stage moves when the result register is free or being drained
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// configuration writes, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chip_id     <= '0;
			cfg_q.order_class <= '0;
			cfg_q.sound_class <= SOUND_CLASS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHIP_ID:     cfg_q.chip_id     <= cfg_data;
				CFG_ORDER_CLASS: cfg_q.order_class <= cfg_data[1:0];
				CFG_SOUND_CLASS: cfg_q.sound_class <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1.is_standard <= is_standard;
			frame_s1.frame_id    <= frame_id;
			frame_s1.b0          <= data_byte0;
			frame_s1.b1          <= data_byte1;
			frame_s1.b2          <= data_byte2;
			frame_s1.b3          <= data_byte3;
			frame_s1.b4          <= data_byte4;
			frame_s1.b5          <= data_byte5;
			frame_s1.b6          <= data_byte6;
			frame_s1.b7          <= data_byte7;
			frame_s1.relay_hold  <= relay_hold;
		end
	end

	// frame decode against the current node state
	cnd_decode u_decode (
		.frame (frame_s1),
		.cur   (state_q),
		.cfg   (cfg_q),
		.nxt   (state_nxt),
		.res   (result_nxt)
	);

	// node state commits as the word leaves the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.assigned  <= 1'b0;
			state_q.node      <= NODE_UNASSIGNED;
			state_q.heartbeat <= 1'b1;
			state_q.clock     <= '0;
			state_q.sound     <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q    <= result_nxt;
			out_state_q <= state_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_code    = result_q.reply;
	assign action_mask   = result_q.mask;
	assign action_value  = result_q.value;
	assign node_id       = out_state_q.node;
	assign assigned      = out_state_q.assigned;
	assign heartbeat_on  = out_state_q.heartbeat;
	assign clock_value   = out_state_q.clock;
	assign sound_payload = out_state_q.sound;

	// an unassigned node always reports the unassigned number
	`CND_ASSERT_SAME(a_unassigned_node, out_valid && !assigned, node_id == NODE_UNASSIGNED)

	// an assigned node number stays inside the legal range
	`CND_ASSERT_SAME(a_node_range, out_valid && assigned,
		node_id >= NODE_MIN[5:0] && node_id <= NODE_MAX[5:0])

	// a setting value only comes with a charge or volume action
	`CND_ASSERT_SAME(a_value_action, out_valid && action_value != '0,
		(action_mask & (ACT_CHARGE | ACT_VOLUME)) != '0)

	// a stalled result keeps the input stage from being overwritten
	`CND_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && out_valid_q && !out_ready, valid_s1)

endmodule

### dv/tb_can_node_command_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_can_node_command_decoder
// self-checking bench: frames go in on the valid/ready input channel, a
// scoreboard predicts the node state and reply for every accepted word and
// compares each result word in order; both sides idle at random
// ---------------------------------------------------------------------------

import cnd_pkg::*;

typedef struct packed {
	reply_t      reply;
	logic [6:0]  mask;
	logic [7:0]  value;
	logic [5:0]  node;
	logic        assigned;
	logic        heartbeat;
	logic [47:0] clock;
	logic [63:0] sound;
} node_result_t;

class frame_scoreboard;
	logic [31:0]  chip_id     = '0;
	logic [1:0]   order_class = 2'd0;
	logic [1:0]   sound_class = SOUND_CLASS_RST;
	logic         assigned_q  = 1'b0;
	logic [5:0]   node_q      = NODE_UNASSIGNED;
	logic         heartbeat_q = 1'b1;
	logic [47:0]  clock_q     = '0;
	logic [63:0]  sound_q     = '0;
	node_result_t pending_replies[$];
	int           errors      = 0;

	function void write_reg(logic [1:0] index, logic [31:0] data);
		case (index)
			CFG_CHIP_ID:     chip_id = data;
			CFG_ORDER_CLASS: order_class = data[1:0];
			CFG_SOUND_CLASS: sound_class = data[1:0];
			default: ;
		endcase
	endfunction

	function bit is_cmd(frame_t f, logic [7:0] code);
		return f.b0 == code && f.b1 == CMD_MARK;
	endfunction

	// command-class decode; returns 1 when the sound test is skipped
	function bit run_command(frame_t f, inout node_result_t r);
		logic [31:0] chip;
		bit          id_ok;
		chip  = {f.b5, f.b4, f.b3, f.b2};
		id_ok = f.b6 >= NODE_MIN && f.b6 <= NODE_MAX;
		if (f.b0 == PWR_OFF_BYTE0 && f.b1 == PWR_OFF_BYTE1)
			r.mask |= ACT_POWER_OFF;
		if ((!assigned_q || node_q == NODE_UNASSIGNED) && !f.relay_hold) begin
			if (is_cmd(f, CMD_ID_ASSIGN) && chip == '0 && id_ok) begin
				assigned_q = 1'b1;
				node_q     = f.b6[5:0];
				r.reply    = REPLY_ACK_ID;
				r.mask    |= ACT_RELAY | ACT_BATTERY;
			end
			return 1;
		end
		if (assigned_q && !f.relay_hold) begin
			if (is_cmd(f, CMD_TIME_SET)) begin
				clock_q = {f.b2, f.b3, f.b4, f.b5, f.b6, f.b7};
				r.mask |= ACT_TIME;
				return 1;
			end
			if (is_cmd(f, CMD_ID_ASSIGN) && chip == chip_id) begin
				if (id_ok) begin
					node_q  = f.b6[5:0];
					r.mask |= ACT_RELAY;
					r.reply = REPLY_ACK_ID;
				end
				return 1;
			end
		end
		if (is_cmd(f, CMD_HB_OFF)) begin
			heartbeat_q = 1'b0;
			return 1;
		end
		if (is_cmd(f, CMD_HB_ON)) begin
			heartbeat_q = 1'b1;
			return 1;
		end
		if (is_cmd(f, CMD_FLASH_CLR)) begin
			r.reply = REPLY_FLASH;
			return 1;
		end
		if (f.frame_id[6:0] == {1'b0, node_q}) begin
			if (is_cmd(f, CMD_CHARGE)) begin
				r.mask |= ACT_CHARGE;
				r.value = f.b2;
				r.reply = REPLY_ACK_ID;
				return 1;
			end
			if (is_cmd(f, CMD_HISTORY)) begin
				r.reply = REPLY_HISTORY;
				return 1;
			end
			if (is_cmd(f, CMD_CHIP_ID)) begin
				r.reply = REPLY_CHIP_ID;
				return 1;
			end
			if (is_cmd(f, CMD_VOLUME)) begin
				r.mask |= ACT_VOLUME;
				r.value = f.b2;
				r.reply = REPLY_ACK_ID;
				return 1;
			end
		end
		return 0;
	endfunction

	function void note_frame(frame_t f);
		node_result_t r;
		bit           done;
		r       = '0;
		r.reply = REPLY_NONE;
		done    = 0;
		if (f.is_standard) begin
			if (f.frame_id[10:9] == order_class)
				done = run_command(f, r);
			if (!done && f.frame_id[8:7] == sound_class) begin
				sound_q = {f.b7, f.b6, f.b5, f.b4, f.b3, f.b2, f.b1, f.b0};
				r.mask |= ACT_SOUND;
			end
		end
		r.node      = node_q;
		r.assigned  = assigned_q;
		r.heartbeat = heartbeat_q;
		r.clock     = clock_q;
		r.sound     = sound_q;
		pending_replies.push_back(r);
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function void check_reply(node_result_t got);
		node_result_t want;
		if (pending_replies.size() == 0) begin
			errors++;
			$display("%0t: result word with no frame pending, expected none, actual %0h",
				$time, got);
			return;
		end
		want = pending_replies.pop_front();
		compare_field("reply_code", want.reply, got.reply);
		compare_field("action_mask", want.mask, got.mask);
		compare_field("action_value", want.value, got.value);
		compare_field("node_id", want.node, got.node);
		compare_field("assigned", want.assigned, got.assigned);
		compare_field("heartbeat_on", want.heartbeat, got.heartbeat);
		compare_field("clock_value", want.clock, got.clock);
		compare_field("sound_payload", want.sound, got.sound);
	endfunction
endclass

module tb_can_node_command_decoder;

	// index past the register list, writes to it must be dropped
	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	// a byte 0 value that is no command at all
	localparam logic [7:0] CODE_UNKNOWN = 8'h7f;
	localparam int         IDLE_PCT     = 30;
	// cycles with no handshake on any channel before giving up
	localparam int         STALL_LIMIT  = 4000;

	logic        clk;
	logic        arst_n       = 1'b0;

	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        is_standard  = 1'b0;
	logic [10:0] frame_id     = '0;
	logic [7:0]  data_byte0   = '0;
	logic [7:0]  data_byte1   = '0;
	logic [7:0]  data_byte2   = '0;
	logic [7:0]  data_byte3   = '0;
	logic [7:0]  data_byte4   = '0;
	logic [7:0]  data_byte5   = '0;
	logic [7:0]  data_byte6   = '0;
	logic [7:0]  data_byte7   = '0;
	logic        relay_hold   = 1'b0;

	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [2:0]  reply_code;
	logic [6:0]  action_mask;
	logic [7:0]  action_value;
	logic [5:0]  node_id;
	logic        assigned;
	logic        heartbeat_on;
	logic [47:0] clock_value;
	logic [63:0] sound_payload;

	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = '0;
	logic [31:0] cfg_data     = '0;

	frame_scoreboard sb;
	// set for a stretch of the run where neither side idles
	bit              quiet        = 1'b0;
	int              stall_cycles = 0;

	can_node_command_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.is_standard   (is_standard),
		.frame_id      (frame_id),
		.data_byte0    (data_byte0),
		.data_byte1    (data_byte1),
		.data_byte2    (data_byte2),
		.data_byte3    (data_byte3),
		.data_byte4    (data_byte4),
		.data_byte5    (data_byte5),
		.data_byte6    (data_byte6),
		.data_byte7    (data_byte7),
		.relay_hold    (relay_hold),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reply_code    (reply_code),
		.action_mask   (action_mask),
		.action_value  (action_value),
		.node_id       (node_id),
		.assigned      (assigned),
		.heartbeat_on  (heartbeat_on),
		.clock_value   (clock_value),
		.sound_payload (sound_payload),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// identifier from command class, sound class and node address
	function automatic logic [10:0] id_of(logic [1:0] cls, logic [1:0] snd, logic [6:0] addr);
		return {cls, snd, addr};
	endfunction

	// tail holds bytes 2..7 with byte 2 in the top bits
	function automatic frame_t mk(bit std, logic [10:0] fid, logic [7:0] code,
			logic [7:0] mark, logic [47:0] tail, bit hold);
		frame_t f;
		f.is_standard = std;
		f.frame_id    = fid;
		f.b0          = code;
		f.b1          = mark;
		{f.b2, f.b3, f.b4, f.b5, f.b6, f.b7} = tail;
		f.relay_hold  = hold;
		return f;
	endfunction

	// class register word: random upper bits, class in the low two
	function automatic logic [31:0] class_word(logic [1:0] cls);
		logic [31:0] w;
		w      = $urandom;
		w[1:0] = cls;
		return w;
	endfunction

	// mostly well-formed commands aimed at this node, with random content
	function automatic frame_t random_frame();
		frame_t      f;
		logic [7:0]  code;
		logic [31:0] chip;
		f.is_standard = ($urandom_range(99) < 93);
		f.frame_id    = 11'($urandom_range(2047));
		if ($urandom_range(99) < 80)
			f.frame_id[10:9] = sb.order_class;
		if ($urandom_range(99) < 50)
			f.frame_id[8:7] = sb.sound_class;
		if ($urandom_range(99) < 70)
			f.frame_id[6:0] = {1'b0, sb.node_q};
		f.b1 = 8'($urandom);
		f.b2 = 8'($urandom);
		f.b3 = 8'($urandom);
		f.b4 = 8'($urandom);
		f.b5 = 8'($urandom);
		f.b6 = 8'($urandom);
		f.b7 = 8'($urandom);
		case ($urandom_range(11))
			0:       code = CMD_TIME_SET;
			1:       code = CMD_HB_OFF;
			2:       code = CMD_HB_ON;
			3:       code = CMD_FLASH_CLR;
			4:       code = CMD_HISTORY;
			5:       code = CMD_CHIP_ID;
			6, 7:    code = CMD_ID_ASSIGN;
			8:       code = CMD_CHARGE;
			9:       code = CMD_VOLUME;
			10:      code = PWR_OFF_BYTE0;
			default: code = 8'($urandom);
		endcase
		f.b0 = code;
		if (code == PWR_OFF_BYTE0)
			f.b1 = PWR_OFF_BYTE1;
		else if ($urandom_range(99) < 88)
			f.b1 = CMD_MARK;
		if (code == CMD_ID_ASSIGN) begin
			if (!sb.assigned_q)
				chip = ($urandom_range(99) < 70) ? 32'd0 : 32'($urandom);
			else
				chip = ($urandom_range(99) < 70) ? sb.chip_id : 32'($urandom);
			{f.b5, f.b4, f.b3, f.b2} = chip;
			if ($urandom_range(99) < 80)
				f.b6 = 8'($urandom_range(60, 1));
		end
		f.relay_hold = ($urandom_range(99) < 12);
		return f;
	endfunction

	// offer one word, possibly after a random gap, and hold it until taken
	task automatic send_frame(frame_t f);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < IDLE_PCT) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		is_standard <= f.is_standard;
		frame_id    <= f.frame_id;
		data_byte0  <= f.b0;
		data_byte1  <= f.b1;
		data_byte2  <= f.b2;
		data_byte3  <= f.b3;
		data_byte4  <= f.b4;
		data_byte5  <= f.b5;
		data_byte6  <= f.b6;
		data_byte7  <= f.b7;
		relay_hold  <= f.relay_hold;
		do @(posedge clk); while (!in_ready);
		sb.note_frame(f);
	endtask

	task automatic run_random(int count);
		repeat (count) send_frame(random_frame());
	endtask

	// stop offering words and let every pending result come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		// result register sits two stages back, leave some slack
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(logic [1:0] index, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: check on every handshake, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_reply(node_result_t'({reply_code, action_mask, action_value,
					node_id, assigned, heartbeat_on, clock_value, sound_payload}));
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on lack of progress on all three channels
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("can_node_command_decoder regression: fail");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset classes: command class 0, sound class 3, chip number 0
		// extended frame is dropped whatever it carries
		send_frame(mk(0, 11'h7ff, CMD_ID_ASSIGN, CMD_MARK, 48'h0000_0000_0100, 0));
		// sound word outside the command class still lands while unassigned
		send_frame(mk(1, id_of(2'd3, 2'd3, 7'h00), 8'h01, 8'h02, 48'h0304_0506_0708, 0));
		// power-off pattern while unassigned, decode stops after the pulse
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), PWR_OFF_BYTE0, PWR_OFF_BYTE1,
			48'hffff_ffff_ffff, 0));
		// assign with nonzero chip number, new number 0 and 61: all ignored
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_ID_ASSIGN, CMD_MARK,
			48'h0100_0000_0500, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_0000, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_3d00, 0));
		// relay hold lets unassigned frames reach the general commands
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_HB_OFF, CMD_MARK, 48'h0, 1));
		// held assign addressed to 63 falls all the way to sound storage
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3f), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_0aff, 1));
		// held chip-id request addressed to 63 gets answered
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3f), CMD_CHIP_ID, CMD_MARK, 48'h0, 1));
		// heartbeat on without hold is swallowed while unassigned
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_HB_ON, CMD_MARK, 48'h0, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_HB_ON, CMD_MARK, 48'h0, 1));
		// proper assign to node 60
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h00), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_3c00, 0));
		// time set all ones, time set under hold, time set all zeros
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_TIME_SET, CMD_MARK,
			48'hffff_ffff_ffff, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_TIME_SET, CMD_MARK,
			48'h1122_3344_5566, 1));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_TIME_SET, CMD_MARK, 48'h0, 0));
		// re-assign: matching chip with bad number, wrong chip, then to node 1
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_3d00, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_ID_ASSIGN, CMD_MARK,
			48'hffff_ffff_0100, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h3c), CMD_ID_ASSIGN, CMD_MARK,
			48'h0000_0000_0100, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_FLASH_CLR, CMD_MARK, 48'h0, 0));
		// node-addressed requests to node 1
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_CHARGE, CMD_MARK,
			48'hff00_0000_0000, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_HISTORY, CMD_MARK, 48'h0, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_CHIP_ID, CMD_MARK, 48'h0, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_VOLUME, CMD_MARK,
			48'h8000_0000_0000, 0));
		// address with bit 6 set never matches, falls to sound
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h41), CMD_VOLUME, CMD_MARK,
			48'h4000_0000_0000, 0));
		// unknown code falls to sound, then heartbeat off once assigned
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CODE_UNKNOWN, CMD_MARK,
			48'hfedc_ba98_7654, 0));
		send_frame(mk(1, id_of(2'd0, 2'd3, 7'h01), CMD_HB_OFF, CMD_MARK, 48'h0, 0));
		run_random(200);
		drain();

		// all-ones chip number, top command class, sound class 0
		program_reg(CFG_CHIP_ID, 32'hffff_ffff);
		program_reg(CFG_ORDER_CLASS, class_word(2'd3));
		program_reg(CFG_SOUND_CLASS, class_word(2'd0));
		program_reg(CFG_UNUSED, $urandom);
		run_random(240);
		drain();

		// no idling on either side for this whole phase
		program_reg(CFG_CHIP_ID, $urandom);
		program_reg(CFG_ORDER_CLASS, class_word(2'd1));
		program_reg(CFG_SOUND_CLASS, class_word(2'd2));
		quiet = 1'b1;
		run_random(240);
		drain();
		quiet = 1'b0;

		program_reg(CFG_CHIP_ID, 32'h0000_0000);
		program_reg(CFG_ORDER_CLASS, class_word(2'd2));
		program_reg(CFG_SOUND_CLASS, class_word(2'd2));
		run_random(240);
		drain();

		// back to the reset classes with a random chip number
		program_reg(CFG_CHIP_ID, $urandom);
		program_reg(CFG_ORDER_CLASS, class_word(2'd0));
		program_reg(CFG_SOUND_CLASS, class_word(SOUND_CLASS_RST));
		run_random(230);
		drain();

		if (sb.errors == 0)
			$display("can_node_command_decoder regression: pass");
		else
			$display("can_node_command_decoder regression: fail");
		$finish;
	end

endmodule
